// ===== rtl/mbp_pkg.sv =====
// Package for the MIDI byte stream parser: parse state, message types and constants.
// Used by the decoder and the top level; depends on nothing.
`default_nettype none

package mbp_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register index, taken from the word address.
    localparam logic REG_LISTEN_CH = 1'b0;

    localparam logic [7:0] STATUS_BIT = 8'b1000_0000;
    localparam logic [7:0] DATA_MASK  = 8'b0111_1111;
    localparam logic [7:0] KIND_MASK  = 8'b1111_0000;
    localparam logic [7:0] CHAN_MASK  = 8'b0000_1111;

    localparam logic [7:0] RT_FIRST        = 8'hF8;
    localparam logic [7:0] KIND_PROG_CHG   = 8'hC0;
    localparam logic [7:0] KIND_CHAN_PRESS = 8'hD0;
    localparam logic [7:0] KIND_SYSTEM     = 8'hF0;
    localparam logic [7:0] ST_QUARTER      = 8'hF1;
    localparam logic [7:0] ST_SONG_POS     = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL     = 8'hF3;

    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] running_status;
        t_phase     phase;
        logic [6:0] held_first;
        logic [1:0] bytes_expected;
    } t_parse_state;

    typedef struct packed {
        logic [7:0] msg_status;
        logic [6:0] first_data;
        logic [6:0] second_data;
    } t_msg;

    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [7:0] kind;
        kind = st & KIND_MASK;
        if ((st & STATUS_BIT) == 8'd0) begin
            data_count = 2'd0;
        end else if (kind == KIND_PROG_CHG || kind == KIND_CHAN_PRESS) begin
            data_count = 2'd1;
        end else if (kind != KIND_SYSTEM) begin
            data_count = 2'd2;
        end else if (st == ST_QUARTER || st == ST_SONG_SEL) begin
            data_count = 2'd1;
        end else if (st == ST_SONG_POS) begin
            data_count = 2'd2;
        end else begin
            data_count = 2'd0;
        end
    endfunction

    function automatic logic is_voice(input logic [7:0] st);
        is_voice = st[7] && ((st & KIND_MASK) != KIND_SYSTEM);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mbp_rx_if.sv =====
// Valid/ready channel that carries one received MIDI byte per transaction.
// Stands alone; the top level takes it through the sink modport.
`default_nettype none

interface mbp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbp_msg_if.sv =====
// Valid/ready channel that carries one decoded MIDI message per transaction.
// Stands alone; the top level drives it through the source modport.
`default_nettype none

interface mbp_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_status;
    logic [6:0] first_data;
    logic [6:0] second_data;

    modport source (output valid, output msg_status, output first_data,
                    output second_data, input ready);
    modport sink (input valid, input msg_status, input first_data,
                  input second_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbp_decode.sv =====
// Combinational decode of one MIDI byte against the current parse state.
// Depends on mbp_pkg for the state and message types and the data count table.
`default_nettype none

module mbp_decode (
    input  wire logic [7:0]           i_byte,
    input  wire mbp_pkg::t_parse_state i_state,
    input  wire logic [3:0]           i_listen_ch,
    output mbp_pkg::t_parse_state     o_state,
    output logic                      o_emit,
    output mbp_pkg::t_msg             o_msg
);

    logic       w_rt;
    logic       w_status;
    logic [1:0] w_new_count;
    logic [1:0] w_rs_count;
    logic [6:0] w_data;
    logic       w_rs_voice;
    logic       w_fin;
    logic [6:0] w_fin_first;
    logic [6:0] w_fin_second;

    assign w_rt        = (i_byte >= mbp_pkg::RT_FIRST);
    assign w_status    = i_byte[7] && !w_rt;
    assign w_new_count = mbp_pkg::data_count(i_byte);
    assign w_rs_count  = mbp_pkg::data_count(i_state.running_status);
    assign w_data      = i_byte[6:0];
    assign w_rs_voice  = mbp_pkg::is_voice(i_state.running_status);

    // A data byte that completes a message held in running status.
    always_comb begin
        w_fin        = 1'b0;
        w_fin_first  = w_data;
        w_fin_second = 7'd0;
        if (!i_byte[7]) begin
            unique case (i_state.phase)
                mbp_pkg::PH_FIRST: begin
                    w_fin = (i_state.bytes_expected <= 2'd1);
                end
                mbp_pkg::PH_SECOND: begin
                    w_fin        = 1'b1;
                    w_fin_first  = i_state.held_first;
                    w_fin_second = w_data;
                end
                default: begin
                    w_fin = w_rs_voice && (w_rs_count <= 2'd1);
                end
            endcase
        end
    end

    // Next parse state.
    always_comb begin
        o_state = i_state;
        if (w_rt) begin
            o_state = i_state;
        end else if (w_status) begin
            o_state.running_status = i_byte;
            o_state.held_first     = 7'd0;
            o_state.bytes_expected = w_new_count;
            if (w_new_count == 2'd0) begin
                // Zero-length statuses are all system messages: they end at once.
                o_state.phase          = mbp_pkg::PH_STATUS;
                o_state.running_status = 8'd0;
            end else begin
                o_state.phase = mbp_pkg::PH_FIRST;
            end
        end else begin
            unique case (i_state.phase)
                mbp_pkg::PH_FIRST: begin
                    o_state.held_first = w_data;
                    o_state.phase      = mbp_pkg::PH_SECOND;
                end
                mbp_pkg::PH_SECOND: begin
                    o_state.phase = mbp_pkg::PH_STATUS;
                end
                default: begin
                    o_state.phase = mbp_pkg::PH_STATUS;
                    if (w_rs_voice) begin
                        o_state.bytes_expected = w_rs_count;
                        o_state.held_first     = w_data;
                        o_state.phase          = mbp_pkg::PH_SECOND;
                    end
                end
            endcase
            if (w_fin) begin
                o_state.phase = mbp_pkg::PH_STATUS;
                if (!w_rs_voice) begin
                    o_state.running_status = 8'd0;
                end
            end
        end
    end

    // Message output.
    always_comb begin
        o_emit            = 1'b0;
        o_msg.msg_status  = i_byte;
        o_msg.first_data  = 7'd0;
        o_msg.second_data = 7'd0;
        if (w_rt || (w_status && w_new_count == 2'd0)) begin
            o_emit = 1'b1;
        end else if (w_fin) begin
            o_msg.first_data  = w_fin_first;
            o_msg.second_data = w_fin_second;
            if (w_rs_voice) begin
                // Voice messages on other channels are dropped.
                o_emit           = (i_state.running_status[3:0] == i_listen_ch);
                o_msg.msg_status = i_state.running_status & mbp_pkg::KIND_MASK;
            end else begin
                o_emit           = 1'b1;
                o_msg.msg_status = i_state.running_status;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/midi_byte_stream_parser.sv =====
// MIDI byte stream parser with running status. Each accepted byte is held in an input
// register, decoded against the parse state, and any completed message is placed in an
// output register; with the output side ready the block takes one byte per clock cycle.
// A message enters the output register from the byte held in the input register. The
// output register stalls the input register only when a message still waits to be taken.
// Depends on mbp_pkg, mbp_rx_if, mbp_msg_if and mbp_decode.
`default_nettype none

module midi_byte_stream_parser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    mbp_rx_if.sink                               i_rx,
    mbp_msg_if.source                            o_msg,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mbp_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [mbp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [mbp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    mbp_pkg::t_msg         r_msg;
    mbp_pkg::t_parse_state r_state;
    logic [3:0]            r_listen_ch;

    mbp_pkg::t_parse_state n_state;
    logic                  n_in_valid;
    logic                  n_out_valid;
    mbp_pkg::t_msg         w_msg;
    logic                  w_emit;
    logic                  w_advance;
    logic                  w_take;
    logic                  w_cfg_wr;

    mbp_decode u_decode (
        .i_byte      (r_in_byte),
        .i_state     (r_state),
        .i_listen_ch (r_listen_ch),
        .o_state     (n_state),
        .o_emit      (w_emit),
        .o_msg       (w_msg)
    );

    assign w_advance   = r_in_valid && (!r_out_valid || o_msg.ready);
    assign i_rx.ready  = !r_in_valid || w_advance;
    assign w_take      = i_rx.valid && i_rx.ready;
    assign n_in_valid  = w_take || (r_in_valid && !w_advance);
    assign n_out_valid = w_advance ? w_emit : (r_out_valid && !o_msg.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{running_status: 8'd0, phase: mbp_pkg::PH_STATUS,
                             held_first: 7'd0, bytes_expected: 2'd0};
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (w_advance && w_emit) begin
            r_msg <= w_msg;
        end
    end

    assign o_msg.valid       = r_out_valid;
    assign o_msg.msg_status  = r_msg.msg_status;
    assign o_msg.first_data  = r_msg.first_data;
    assign o_msg.second_data = r_msg.second_data;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_ch <= 4'd0;
        end else if (w_cfg_wr && paddr[2] == mbp_pkg::REG_LISTEN_CH) begin
            r_listen_ch <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[2] == mbp_pkg::REG_LISTEN_CH)
                    ? {{(mbp_pkg::APB_DATA_W-4){1'b0}}, r_listen_ch}
                    : {mbp_pkg::APB_DATA_W{1'b0}};

    // While a message is in progress, a status must be held.
    a_phase_has_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != mbp_pkg::PH_STATUS |-> r_state.running_status[7])
        else $error("parse phase active without a running status");

    // Real-time bytes leave the parse state untouched.
    a_rt_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in_byte >= mbp_pkg::RT_FIRST |=> $stable(r_state))
        else $error("real-time byte disturbed the parse state");

    // A message that leaves the block always carries a status byte.
    a_msg_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg.valid |-> o_msg.msg_status[7])
        else $error("emitted message without status bit");

    // Voice messages go out with the channel nibble cleared.
    a_voice_chan_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg.valid && mbp_pkg::is_voice(o_msg.msg_status) |-> o_msg.msg_status[3:0] == 4'd0)
        else $error("voice message emitted with channel bits set");

endmodule

`default_nettype wire
